### design/body_point_classify_smooth_assert.svh
// Assertion macros for the body point classifier.
// Included by the RTL file that carries concurrent checks; needs no package.
`ifndef BODY_POINT_CLASSIFY_SMOOTH_ASSERT_SVH
`define BODY_POINT_CLASSIFY_SMOOTH_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define BPCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpcs check failed");
// Next-cycle implication, checked out of reset.
`define BPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpcs check failed");
`else
`define BPCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/bpcs_pkg.sv
// Shared constants and types for the body point classifier.
// No dependencies; used by body_point_classify_smooth, skeleton_checker and tb.
`default_nettype none

package bpcs_pkg;

  localparam int COORD_BITS    = 10;
  localparam int MAX_POINTS    = 1024;
  localparam int MAX_SKELETONS = 8;

  localparam int REG_BITS    = 10;
  localparam int NUM_REGS    = 8;
  localparam int PADDR_BITS  = $clog2(NUM_REGS) + 2;
  localparam int SLOT_BITS   = 3;
  localparam int CODE_BITS   = 3;
  localparam int NUM_CLASSES = 5;
  localparam int NUM_LIMBS   = 6;

  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int SUM_BITS   = COORD_BITS + $clog2(MAX_POINTS);
  localparam int DCNT_BITS  = $clog2(SUM_BITS);
  localparam int WIDE_BITS  = ((COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS) + 1;
  localparam int CMP_BITS   = WIDE_BITS + 1;
  localparam int HIST_DEPTH = MAX_SKELETONS * NUM_LIMBS;
  localparam int HADDR_BITS = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [REG_BITS-1:0]   creg_t;
  typedef logic [SUM_BITS-1:0]   sum_t;
  typedef logic [CNT_BITS-1:0]   count_t;
  typedef logic [CODE_BITS-1:0]  code_t;

  // Register indexes.
  localparam int REG_HEAD_RISE   = 0;
  localparam int REG_HEAD_WIDTH  = 1;
  localparam int REG_LEG_DROP    = 2;
  localparam int REG_HAND_REACH  = 3;
  localparam int REG_HAND_STEP   = 4;
  localparam int REG_LEG_STEP    = 5;
  localparam int REG_CENTER_STEP = 6;
  localparam int REG_HEAD_STEP   = 7;

  localparam creg_t CFG_RESET [NUM_REGS] = '{
    creg_t'(8), creg_t'(4), creg_t'(8), creg_t'(13),
    creg_t'(4), creg_t'(2), creg_t'(3), creg_t'(2)
  };

  // Limb codes, in output order.
  localparam code_t LIMB_LHAND  = code_t'(0);
  localparam code_t LIMB_RHAND  = code_t'(1);
  localparam code_t LIMB_LLEG   = code_t'(2);
  localparam code_t LIMB_RLEG   = code_t'(3);
  localparam code_t LIMB_CENTER = code_t'(4);
  localparam code_t LIMB_HEAD   = code_t'(5);

  // Accumulator classes; hands and legs share the limb code.
  localparam code_t CLS_HEAD = code_t'(4);

endpackage

`default_nettype wire

### design/body_point_classify_smooth.sv
// Body point classifier: accumulates classified edge points per blob, then
// divides and slew-limits six limbs with one shared restoring divider.
// Usage:
//   Input channel in_*: one edge point per request, with the blob center,
//   slot, history flag and last-point mark. A request is taken when in_valid
//   is high and in_stall is low. Ordinary points are taken one per cycle.
//   A request marked last_point starts the limb sequence; in_stall stays high
//   until the sixth limb has been taken on the output channel.
//   Output channel out_*: six limb requests per blob in code order 0..5,
//   last_limb set on the head. Each limb passes a setup state, two divisions
//   of SUM_BITS bits each (20 at the default widths) unless the class is
//   empty or the limb is the center, a smoothing state and an output state.
//   The six limbs use the single shift-subtract divider in turn, and the
//   receiver may hold out_stall. A stalled limb holds its payload.
//   Configuration: APB-style write port, eight 10-bit registers at 4*i, to be
//   written only while the block is idle; the block does not enforce this.
//   Reset (rst_n low, synchronous) restores the register defaults and clears
//   the accumulators and the sequencer. The per-slot history memory is not
//   cleared; a slot must be written once before it is used as history.
`default_nettype none

module body_point_classify_smooth (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [bpcs_pkg::SLOT_BITS-1:0]      in_slot,
  input  wire logic [bpcs_pkg::COORD_BITS-1:0]     in_center_x,
  input  wire logic [bpcs_pkg::COORD_BITS-1:0]     in_center_y,
  input  wire logic [bpcs_pkg::COORD_BITS-1:0]     in_point_x,
  input  wire logic [bpcs_pkg::COORD_BITS-1:0]     in_point_y,
  input  wire logic                                in_use_history,
  input  wire logic                                in_last_point,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [bpcs_pkg::SLOT_BITS-1:0]           out_slot,
  output logic [bpcs_pkg::CODE_BITS-1:0]           out_limb_code,
  output logic [bpcs_pkg::COORD_BITS-1:0]          out_limb_x,
  output logic [bpcs_pkg::COORD_BITS-1:0]          out_limb_y,
  output logic                                     out_last_limb,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bpcs_pkg::PADDR_BITS-1:0]     paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  localparam int CB  = bpcs_pkg::COORD_BITS;
  localparam int RB  = bpcs_pkg::REG_BITS;
  localparam int SB  = bpcs_pkg::SUM_BITS;
  localparam int NB  = bpcs_pkg::CNT_BITS;
  localparam int WB  = bpcs_pkg::WIDE_BITS;
  localparam int QB  = bpcs_pkg::CMP_BITS;
  localparam int AB  = bpcs_pkg::HADDR_BITS;
  localparam int DB  = bpcs_pkg::DCNT_BITS;
  localparam int NCL = bpcs_pkg::NUM_CLASSES;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_SMOOTH = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  // ---------------------------------------------------------------- config
  localparam int PADDR_BITS_IDX = bpcs_pkg::PADDR_BITS - 2;

  bpcs_pkg::creg_t cfg_r [bpcs_pkg::NUM_REGS];
  logic            cfg_we;
  logic [PADDR_BITS_IDX-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[bpcs_pkg::PADDR_BITS-1:2];
  assign cfg_we  = psel && penable && pwrite;
  assign prdata  = {{(32-RB){1'b0}}, cfg_r[cfg_idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bpcs_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= bpcs_pkg::CFG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg_r[cfg_idx] <= pwdata[RB-1:0];
    end
  end

  // -------------------------------------------------------- classification
  logic [2:0]       state_r, state_nxt;
  logic             in_acc;
  logic signed [QB-1:0] dx, dy, adx, ndy;
  logic signed [QB-1:0] th_rise, th_width, th_drop, th_reach;
  logic             cls_hit;
  bpcs_pkg::code_t  cls;

  function automatic logic signed [QB-1:0] sx_coord(input logic [CB-1:0] v);
    return $signed({{(QB-CB){1'b0}}, v});
  endfunction

  function automatic logic signed [QB-1:0] sx_reg(input logic [RB-1:0] v);
    return $signed({{(QB-RB){1'b0}}, v});
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    dx       = sx_coord(in_point_x) - sx_coord(in_center_x);
    dy       = sx_coord(in_point_y) - sx_coord(in_center_y);
    ndy      = -dy;
    adx      = (dx < 0) ? -dx : dx;
    th_rise  = sx_reg(cfg_r[bpcs_pkg::REG_HEAD_RISE]);
    th_width = sx_reg(cfg_r[bpcs_pkg::REG_HEAD_WIDTH]);
    th_drop  = sx_reg(cfg_r[bpcs_pkg::REG_LEG_DROP]);
    th_reach = sx_reg(cfg_r[bpcs_pkg::REG_HAND_REACH]);
    cls_hit  = 1'b1;
    cls      = bpcs_pkg::CLS_HEAD;
    priority if ((ndy > th_rise) && (adx < th_width)) begin
      cls = bpcs_pkg::CLS_HEAD;
    end else if (dy > th_drop) begin
      cls = (dx > 0) ? bpcs_pkg::LIMB_RLEG : bpcs_pkg::LIMB_LLEG;
    end else if (adx > th_reach) begin
      cls = (dx > 0) ? bpcs_pkg::LIMB_RHAND : bpcs_pkg::LIMB_LHAND;
    end else begin
      cls_hit = 1'b0;
    end
  end

  // ----------------------------------------------------------- accumulators
  bpcs_pkg::sum_t   sum_x_r [NCL];
  bpcs_pkg::sum_t   sum_y_r [NCL];
  bpcs_pkg::count_t cnt_r   [NCL];
  logic             seq_done;
  logic [2:0]       limb_r;

  assign seq_done = (state_r == ST_OUT) && !out_stall && (limb_r == bpcs_pkg::LIMB_HEAD);

  always_ff @(posedge clk) begin
    if (!rst_n || seq_done) begin
      for (int i = 0; i < NCL; i++) begin
        sum_x_r[i] <= '0;
        sum_y_r[i] <= '0;
        cnt_r[i]   <= '0;
      end
    end else if (in_acc && cls_hit) begin
      for (int i = 0; i < NCL; i++) begin
        if ((cls == bpcs_pkg::code_t'(i)) &&
            (cnt_r[i] < bpcs_pkg::count_t'(bpcs_pkg::MAX_POINTS))) begin
          sum_x_r[i] <= sum_x_r[i] + {{(SB-CB){1'b0}}, in_point_x};
          sum_y_r[i] <= sum_y_r[i] + {{(SB-CB){1'b0}}, in_point_y};
          cnt_r[i]   <= cnt_r[i] + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------- blob context
  logic [bpcs_pkg::SLOT_BITS-1:0] slot_r;
  bpcs_pkg::coord_t               cx_r, cy_r;
  logic                           hist_r;
  logic [AB-1:0]                  base_r;

  // Slot folded onto the available history slots.
  function automatic logic [bpcs_pkg::SLOT_BITS-1:0] slot_fold(
      input logic [bpcs_pkg::SLOT_BITS-1:0] s);
    logic [bpcs_pkg::SLOT_BITS:0] v;
    v = {1'b0, s};
    for (int i = 0; i < (1 << bpcs_pkg::SLOT_BITS); i++) begin
      if (int'(v) >= bpcs_pkg::MAX_SKELETONS) begin
        v = v - (bpcs_pkg::SLOT_BITS+1)'(bpcs_pkg::MAX_SKELETONS);
      end
    end
    return v[bpcs_pkg::SLOT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (in_acc && in_last_point) begin
      slot_r <= in_slot;
      cx_r   <= in_center_x;
      cy_r   <= in_center_y;
      hist_r <= in_use_history;
      base_r <= AB'(int'(slot_fold(in_slot)) * bpcs_pkg::NUM_LIMBS);
    end
  end

  // ---------------------------------------------------------- shared divider
  bpcs_pkg::code_t  lcls;
  bpcs_pkg::sum_t   div_num_r;
  logic [NB-1:0]    div_rem_r;
  logic [DB-1:0]    div_cnt_r;
  logic             div_ph_r;
  logic [NB:0]      rem_sh;
  logic             q_bit;
  logic [NB-1:0]    rem_new;
  bpcs_pkg::sum_t   num_new;
  bpcs_pkg::count_t divisor;
  logic             div_last;

  // The head limb is fed by the head class; others share their code.
  assign lcls    = (limb_r == bpcs_pkg::LIMB_HEAD) ? bpcs_pkg::CLS_HEAD : limb_r;
  assign divisor = cnt_r[lcls];

  always_comb begin
    rem_sh   = {div_rem_r, div_num_r[SB-1]};
    q_bit    = (rem_sh >= {1'b0, divisor});
    rem_new  = q_bit ? NB'(rem_sh - {1'b0, divisor}) : rem_sh[NB-1:0];
    num_new  = {div_num_r[SB-2:0], q_bit};
    div_last = (div_cnt_r == DB'(SB - 1));
  end

  // -------------------------------------------------------- history memory
  logic [2*CB-1:0] hist_mem_r [bpcs_pkg::HIST_DEPTH];
  logic [2*CB-1:0] hist_rd_r;
  logic [AB-1:0]   haddr;
  logic            hist_we;
  bpcs_pkg::coord_t res_x, res_y;

  assign haddr   = base_r + AB'(limb_r);
  assign hist_we = (state_r == ST_SMOOTH);

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem_r[haddr] <= {res_x, res_y};
    end
    if (state_r == ST_START) begin
      hist_rd_r <= hist_mem_r[haddr];
    end
  end

  // ------------------------------------------------------------- smoothing
  bpcs_pkg::coord_t nx_r, ny_r, ox, oy;
  bpcs_pkg::creg_t  lim;

  function automatic bpcs_pkg::coord_t pull_back(input bpcs_pkg::coord_t nv,
                                                 input bpcs_pkg::coord_t ov,
                                                 input bpcs_pkg::creg_t  l);
    logic [WB-1:0] n, o, lw, r;
    n  = {{(WB-CB){1'b0}}, nv};
    o  = {{(WB-CB){1'b0}}, ov};
    lw = {{(WB-RB){1'b0}}, l};
    r  = n;
    if ((n > o) && ((n - o) > lw)) begin
      r = n - lw;
    end else if ((o > n) && ((o - n) > lw)) begin
      r = n + lw;
    end
    return r[CB-1:0];
  endfunction

  always_comb begin
    ox = hist_rd_r[2*CB-1:CB];
    oy = hist_rd_r[CB-1:0];
    unique case (limb_r)
      bpcs_pkg::LIMB_LHAND, bpcs_pkg::LIMB_RHAND: lim = cfg_r[bpcs_pkg::REG_HAND_STEP];
      bpcs_pkg::LIMB_LLEG, bpcs_pkg::LIMB_RLEG:   lim = cfg_r[bpcs_pkg::REG_LEG_STEP];
      bpcs_pkg::LIMB_CENTER:                      lim = cfg_r[bpcs_pkg::REG_CENTER_STEP];
      default:                                    lim = cfg_r[bpcs_pkg::REG_HEAD_STEP];
    endcase
    res_x = nx_r;
    res_y = ny_r;
    if (hist_r) begin
      // A zero coordinate means a lost limb: hold the previous position.
      if (((nx_r == '0) && (ox != '0)) || ((ny_r == '0) && (oy != '0))) begin
        res_x = ox;
        res_y = oy;
      end else if (ox != '0) begin
        res_x = pull_back(nx_r, ox, lim);
        res_y = pull_back(ny_r, oy, lim);
      end
    end
  end

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc && in_last_point) state_nxt = ST_START;
      ST_START: begin
        if ((limb_r == bpcs_pkg::LIMB_CENTER) || (divisor == '0)) begin
          state_nxt = ST_SMOOTH;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:    if (div_last && div_ph_r) state_nxt = ST_SMOOTH;
      ST_SMOOTH: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = (limb_r == bpcs_pkg::LIMB_HEAD) ? ST_IDLE : ST_START;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      limb_r    <= bpcs_pkg::LIMB_LHAND;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        limb_r <= bpcs_pkg::LIMB_LHAND;
      end else if ((state_r == ST_OUT) && !out_stall &&
                   (limb_r != bpcs_pkg::LIMB_HEAD)) begin
        limb_r <= limb_r + 1'b1;
      end
      if (state_r == ST_SMOOTH) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Divider datapath and new-limb registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_START: begin
        div_num_r <= sum_x_r[lcls];
        div_rem_r <= '0;
        div_cnt_r <= '0;
        div_ph_r  <= 1'b0;
        if (limb_r == bpcs_pkg::LIMB_CENTER) begin
          nx_r <= cx_r;
          ny_r <= cy_r;
        end else begin
          nx_r <= '0;
          ny_r <= '0;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          div_num_r <= sum_y_r[lcls];
          div_rem_r <= '0;
          div_cnt_r <= '0;
          div_ph_r  <= 1'b1;
          if (div_ph_r) begin
            ny_r <= num_new[CB-1:0];
          end else begin
            nx_r <= num_new[CB-1:0];
          end
        end else begin
          div_num_r <= num_new;
          div_rem_r <= rem_new;
          div_cnt_r <= div_cnt_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SMOOTH) begin
      out_slot      <= slot_r;
      out_limb_code <= limb_r;
      out_limb_x    <= res_x;
      out_limb_y    <= res_y;
      out_last_limb <= (limb_r == bpcs_pkg::LIMB_HEAD);
    end
  end

  // ------------------------------------------------------------- assertions
`include "body_point_classify_smooth_assert.svh"

  `BPCS_ASSERT_NOW(a_idle_no_result, clk, rst_n, !in_stall, !out_valid)
  `BPCS_ASSERT_NOW(a_last_is_head, clk, rst_n, out_valid && out_last_limb,
                   out_limb_code == bpcs_pkg::LIMB_HEAD)
  `BPCS_ASSERT_NEXT(a_busy_after_last, clk, rst_n, in_acc && in_last_point, in_stall)
  `BPCS_ASSERT_NEXT(a_more_limbs, clk, rst_n, out_valid && !out_stall && !out_last_limb,
                    in_stall)
  `BPCS_ASSERT_NOW(a_div_bound, clk, rst_n, state_r == ST_DIV,
                   int'(div_cnt_r) < bpcs_pkg::SUM_BITS)

endmodule

`default_nettype wire

### tb/skeleton_checker.sv
`timescale 1ns / 100ps
// Limb checker for body_point_classify_smooth: watches the point and limb
// channels and the register writes, predicts each blob's six limbs and compares.
// Depends on bpcs_pkg for widths, register indexes and limb codes.
module skeleton_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bpcs_pkg::SLOT_BITS-1:0] in_slot,
  input  bpcs_pkg::coord_t              in_center_x,
  input  bpcs_pkg::coord_t              in_center_y,
  input  bpcs_pkg::coord_t              in_point_x,
  input  bpcs_pkg::coord_t              in_point_y,
  input  logic                          in_use_history,
  input  logic                          in_last_point,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [bpcs_pkg::SLOT_BITS-1:0] out_slot,
  input  bpcs_pkg::code_t               out_limb_code,
  input  bpcs_pkg::coord_t              out_limb_x,
  input  bpcs_pkg::coord_t              out_limb_y,
  input  logic                          out_last_limb,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [bpcs_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output int                            fails,
  output int                            pending
);
  import bpcs_pkg::*;

  localparam int NO_CLASS = -1;

  typedef struct packed {
    logic [SLOT_BITS-1:0] slot;
    code_t                code;
    coord_t               x;
    coord_t               y;
    logic                 last;
  } limb_t;

  creg_t                   knob [NUM_REGS];
  sum_t                    sum_x [NUM_CLASSES];
  sum_t                    sum_y [NUM_CLASSES];
  count_t                  hits [NUM_CLASSES];
  logic [2*COORD_BITS-1:0] history [HIST_DEPTH];
  limb_t                   limbs_due [$];

  function automatic int classify(coord_t cx, coord_t cy, coord_t px, coord_t py);
    int dx, dy, adx;
    dx = int'(px) - int'(cx);
    dy = int'(py) - int'(cy);
    adx = (dx < 0) ? -dx : dx;
    if (-dy > int'(knob[REG_HEAD_RISE]) && adx < int'(knob[REG_HEAD_WIDTH]))
      return int'(CLS_HEAD);
    if (dy > int'(knob[REG_LEG_DROP]))
      return (dx > 0) ? int'(LIMB_RLEG) : int'(LIMB_LLEG);
    if (adx > int'(knob[REG_HAND_REACH]))
      return (dx > 0) ? int'(LIMB_RHAND) : int'(LIMB_LHAND);
    return NO_CLASS;
  endfunction

  function automatic creg_t step_limit(code_t code);
    case (code)
      LIMB_LHAND, LIMB_RHAND: return knob[REG_HAND_STEP];
      LIMB_LLEG, LIMB_RLEG:   return knob[REG_LEG_STEP];
      LIMB_CENTER:            return knob[REG_CENTER_STEP];
      default:                return knob[REG_HEAD_STEP];
    endcase
  endfunction

  function automatic coord_t pull(coord_t nv, coord_t ov, creg_t lim);
    if (nv > ov && nv - ov > lim) return nv - lim;
    if (ov > nv && ov - nv > lim) return nv + lim;
    return nv;
  endfunction

  // A zero coordinate against a known old one keeps the old limb; a zero old
  // column means there is nothing to limit against.
  function automatic logic [2*COORD_BITS-1:0] slew(coord_t nx, coord_t ny, coord_t ox,
                                                   coord_t oy, creg_t lim);
    if ((nx == '0 && ox != '0) || (ny == '0 && oy != '0)) return {ox, oy};
    if (ox != '0) return {pull(nx, ox, lim), pull(ny, oy, lim)};
    return {nx, ny};
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: limb %s expected %0d, got %0d", $time, what, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    limb_t                   want;
    int                      cls, hidx;
    code_t                   code;
    coord_t                  nx, ny;
    logic [2*COORD_BITS-1:0] old;
    if (!rst_n) begin
      knob = CFG_RESET;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        sum_x[c] = '0;
        sum_y[c] = '0;
        hits[c] = '0;
      end
      limbs_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && int'(paddr >> 2) < NUM_REGS)
        knob[paddr >> 2] = pwdata[REG_BITS-1:0];

      if (out_valid && !out_stall) begin
        if (limbs_due.size() == 0) begin
          $display("%0t: limb request with none expected: slot %0d code %0d (%0d,%0d)",
                   $time, out_slot, out_limb_code, out_limb_x, out_limb_y);
          fails++;
        end else begin
          want = limbs_due.pop_front();
          check_field("slot", 32'(want.slot), 32'(out_slot));
          check_field("code", 32'(want.code), 32'(out_limb_code));
          check_field("x", 32'(want.x), 32'(out_limb_x));
          check_field("y", 32'(want.y), 32'(out_limb_y));
          check_field("last", 32'(want.last), 32'(out_last_limb));
        end
      end

      if (in_valid && !in_stall) begin
        cls = classify(in_center_x, in_center_y, in_point_x, in_point_y);
        if (cls != NO_CLASS && int'(hits[cls]) < MAX_POINTS) begin
          sum_x[cls] = sum_x[cls] + sum_t'(in_point_x);
          sum_y[cls] = sum_y[cls] + sum_t'(in_point_y);
          hits[cls] = hits[cls] + count_t'(1);
        end
        if (in_last_point) begin
          for (int k = 0; k < NUM_LIMBS; k++) begin
            code = code_t'(k);
            cls = (code == LIMB_HEAD) ? int'(CLS_HEAD) : k;
            if (code == LIMB_CENTER) begin
              nx = in_center_x;
              ny = in_center_y;
            end else if (hits[cls] == '0) begin
              nx = '0;
              ny = '0;
            end else begin
              nx = coord_t'(sum_x[cls] / sum_t'(hits[cls]));
              ny = coord_t'(sum_y[cls] / sum_t'(hits[cls]));
            end
            hidx = (int'(in_slot) % MAX_SKELETONS) * NUM_LIMBS + k;
            if (in_use_history) begin
              old = history[hidx];
              {nx, ny} = slew(nx, ny, old[2*COORD_BITS-1:COORD_BITS],
                              old[COORD_BITS-1:0], step_limit(code));
            end
            history[hidx] = {nx, ny};
            want = '{in_slot, code, nx, ny, code == LIMB_HEAD};
            limbs_due = {limbs_due, want};
          end
          for (int c = 0; c < NUM_CLASSES; c++) begin
            sum_x[c] = '0;
            sum_y[c] = '0;
            hits[c] = '0;
          end
        end
      end
    end
    pending = limbs_due.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for body_point_classify_smooth: sends blobs of edge points,
// programs the thresholds, stalls the limb channel and prints the verdict.
// Depends on bpcs_pkg, the block and skeleton_checker.
module tb;
  import bpcs_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_POINTS = 300;
  localparam int NUM_PHASES    = 6;
  localparam int KNOBS_ZERO    = 0;
  localparam int KNOBS_FULL    = 1;
  localparam int KNOBS_MIXED   = 2;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SLOT_BITS-1:0]  in_slot = '0;
  coord_t                in_center_x = '0;
  coord_t                in_center_y = '0;
  coord_t                in_point_x = '0;
  coord_t                in_point_y = '0;
  logic                  in_use_history = 1'b0;
  logic                  in_last_point = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SLOT_BITS-1:0]  out_slot;
  code_t                 out_limb_code;
  coord_t                out_limb_x;
  coord_t                out_limb_y;
  logic                  out_last_limb;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int                     fails;
  int                     pending;
  int                     quiet_cycles = 0;
  logic                   steady = 1'b0;
  logic [MAX_SKELETONS-1:0] slot_seen = '0;

  body_point_classify_smooth dut (.*);
  skeleton_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) out_stall <= !steady && ($urandom_range(0, 99) < 8);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_point(input logic [SLOT_BITS-1:0] slot, input coord_t cx,
                            input coord_t cy, input coord_t px, input coord_t py,
                            input logic hist, input logic last);
    if (!steady && $urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_slot <= slot;
    in_center_x <= cx;
    in_center_y <= cy;
    in_point_x <= px;
    in_point_y <= py;
    in_use_history <= hist;
    in_last_point <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (last) slot_seen[int'(slot) % MAX_SKELETONS] = 1'b1;
  endtask

  // Hold off new requests until every predicted limb has been taken.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input creg_t value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_BITS'(4 * idx);
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_knobs(input int mode);
    creg_t value;
    for (int idx = 0; idx < NUM_REGS; idx++) begin
      if (mode == KNOBS_ZERO)
        value = '0;
      else if (mode == KNOBS_FULL)
        value = '1;
      else if ($urandom_range(0, 7) == 0)
        value = creg_t'($urandom);
      else if (idx <= REG_HAND_REACH)
        value = creg_t'($urandom_range(0, 40));
      else
        value = creg_t'($urandom_range(0, 12));
      write_reg(idx, value);
    end
  endtask

  // Mostly close to the center so that every class gets hit.
  function automatic coord_t near(coord_t c);
    int v;
    if ($urandom_range(0, 9) < 3) return coord_t'($urandom);
    v = int'(c) + int'($urandom_range(0, 96)) - 48;
    if (v < 0) v = 0;
    if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
    return coord_t'(v);
  endfunction

  task automatic random_blob(output int count);
    logic [SLOT_BITS-1:0] slot;
    coord_t cx, cy;
    logic hist;
    int len;
    slot = SLOT_BITS'($urandom);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
    hist = slot_seen[int'(slot) % MAX_SKELETONS] && ($urandom_range(0, 3) != 0);
    cx = coord_t'($urandom);
    cy = coord_t'($urandom);
    for (int i = 0; i < len; i++) begin
      // The center drifts now and then in a blob; the last is the center limb.
      if ($urandom_range(0, 19) == 0) begin
        cx = coord_t'($urandom);
        cy = coord_t'($urandom);
      end
      if (i == len - 1)
        send_point(slot, cx, cy, near(cx), near(cy), hist, 1'b1);
      else
        send_point(slot, cx, cy, near(cx), near(cy), 1'($urandom), 1'b0);
    end
    count = len;
  endtask

  initial begin
    int sent, count;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed blobs under the reset thresholds. First every class, with the
    // boundary points that just miss head, head width and hand reach.
    send_point(0, 512, 512, 512, 500, 0, 0);
    send_point(0, 512, 512, 512, 504, 0, 0);
    send_point(0, 512, 512, 516, 400, 0, 0);
    send_point(0, 512, 512, 513, 521, 0, 0);
    send_point(0, 512, 512, 512, 521, 0, 0);
    send_point(0, 512, 512, 498, 512, 0, 0);
    send_point(0, 512, 512, 526, 512, 0, 0);
    send_point(0, 512, 512, 525, 512, 0, 0);
    send_point(0, 512, 512, 0, 0, 0, 1);
    // Empty classes and a zero center keep the old limbs; the far leg is
    // pulled back.
    send_point(0, 0, 0, 1023, 1023, 0, 0);
    send_point(0, 0, 0, 0, 0, 1, 1);
    // A slot whose stored center and head have a zero column.
    send_point(1, 0, 700, 0, 600, 0, 0);
    send_point(1, 0, 700, 1023, 700, 0, 1);
    send_point(1, 5, 690, 3, 640, 0, 0);
    send_point(1, 5, 690, 900, 695, 1, 0);
    send_point(1, 5, 690, 512, 690, 1, 1);
    send_point(7, 1023, 1023, 1023, 0, 0, 1);
    // Zero row only, on a hand and on the center.
    send_point(0, 500, 0, 800, 0, 1, 1);
    settle();

    // One class past its point limit; the extra points would pull the mean.
    for (int i = 0; i < MAX_POINTS + 6; i++) begin
      if (i < MAX_POINTS)
        send_point(2, 1023, 512, coord_t'($urandom_range(0, 900)), 512, 0, 0);
      else
        send_point(2, 1023, 512, 0, 512, 0, i == MAX_POINTS + 5);
    end
    settle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      load_knobs(phase == 0 ? KNOBS_ZERO : phase == 1 ? KNOBS_FULL : KNOBS_MIXED);
      steady = (phase == 3);
      sent = 0;
      while (sent < RANDOM_POINTS / NUM_PHASES) begin
        random_blob(count);
        sent += count;
        if ($urandom_range(0, 7) == 0) settle();
      end
      settle();
    end

    if (fails == 0 && pending == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

### body_point_classify_smooth.f
+incdir+design
design/bpcs_pkg.sv
design/body_point_classify_smooth.sv
tb/skeleton_checker.sv
tb/tb.sv
